// ===== design/plc_pkg.sv =====
// Package for the plane local coordinates pipeline.
// Holds step counts, fixed-point limits, sideband structs and rounding helpers.
// No dependencies.
`default_nettype none
package plc_pkg;

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 31;
    localparam int NUM_W     = 62;
    localparam int OFF_W     = 34;

    localparam logic signed [31:0] ONE_Q28   = 32'sd268435456;
    localparam logic [30:0]        ONE_Q30   = 31'd1073741824;
    localparam logic signed [65:0] VP_LIMIT  = 66'sd2147483647;
    localparam logic signed [65:0] OFF_LIMIT = 66'sd8589934591;
    localparam logic signed [65:0] OUT_MAX   = 66'sd2147483647;
    localparam logic signed [65:0] OUT_MIN   = -66'sd2147483648;

    typedef logic [2:0][OFF_W-1:0] t_off3;

    typedef struct packed {
        t_off3            off;
        logic [2:0][31:0] bp;
    } t_side1;

    typedef struct packed {
        t_off3            off;
        logic [2:0][31:0] u;
    } t_side2;

    localparam int SIDE_W = $bits(t_side1);

    function automatic logic signed [65:0] sround(input logic signed [65:0] x, input int sh);
        logic signed [65:0] half;
        half = 66'sd1 <<< (sh - 1);
        if (x >= 0) begin
            return (x + half) >>> sh;
        end
        return -((-x + half) >>> sh);
    endfunction

    function automatic logic signed [65:0] clamp_sym(input logic signed [65:0] x,
                                                     input logic signed [65:0] lim);
        if (x > lim) begin
            return lim;
        end
        if (x < -lim) begin
            return -lim;
        end
        return x;
    endfunction

endpackage
`default_nettype wire

// ===== design/plc_front.sv =====
// Front stages: axis choice, projected model axes, plane origin and offsets.
// Four register stages; uses plc_pkg.
`default_nettype none
module plc_front import plc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2:0][15:0]      i_normal,
    input  logic [2:0][31:0]      i_point,
    input  logic [2:0][31:0]      i_query,
    output logic                  o_valid,
    output logic [2:0][31:0]      o_w,
    output logic [63:0]           o_s,
    output t_side1                o_side
);

    logic [16:0] mx, my, mz;
    logic [1:0]  ia, ib;
    logic signed [32:0] tmp_a, tmp_b;

    logic             r_v1, r_v2, r_v3, r_v4;
    logic [2:0][15:0] n_n1, r_n1, r_n2;
    logic [2:0][31:0] n_ap1, r_ap1, r_ap2, r_ap3, r_ap4;
    logic [2:0][31:0] n_bp1, r_bp1, r_bp2, r_bp3, r_bp4;
    logic [2:0][47:0] n_pn1, r_pn1;
    logic [2:0][31:0] r_q1, r_q2, r_q3;
    logic [2:0][63:0] n_sq2, r_sq2;
    logic [35:0]      n_d2, r_d2;
    logic [63:0]      n_s3, r_s3, r_s4;
    logic [2:0][51:0] n_nd3, r_nd3;
    t_off3            n_off4, r_off4;

    function automatic logic [16:0] abs16(input logic [15:0] x);
        logic signed [16:0] e;
        e = 17'($signed(x));
        return e[16] ? 17'(-e) : 17'(e);
    endfunction

    always_comb begin
        n_n1 = i_normal;
        mx = abs16(i_normal[0]);
        my = abs16(i_normal[1]);
        mz = abs16(i_normal[2]);
        if (mz >= mx && mz >= my) begin
            ia = 2'd0;
            ib = 2'd1;
        end else if (my >= mx) begin
            ia = 2'd0;
            ib = 2'd2;
        end else begin
            ia = 2'd1;
            ib = 2'd2;
        end
        for (int k = 0; k < 3; k++) begin
            tmp_a = ((ia == 2'(k)) ? 33'(ONE_Q28) : 33'sd0)
                    - 33'($signed(i_normal[ia]) * $signed(i_normal[k]));
            tmp_b = ((ib == 2'(k)) ? 33'(ONE_Q28) : 33'sd0)
                    - 33'($signed(i_normal[ib]) * $signed(i_normal[k]));
            n_ap1[k] = tmp_a[31:0];
            n_bp1[k] = tmp_b[31:0];
            n_pn1[k] = 48'($signed(i_point[k]) * $signed(i_normal[k]));
        end
    end

    always_comb begin
        n_d2 = 36'(sround(66'($signed(r_pn1[0])) + 66'($signed(r_pn1[1]))
                          + 66'($signed(r_pn1[2])), 14));
        for (int k = 0; k < 3; k++) begin
            n_sq2[k] = 64'($signed(r_ap1[k]) * $signed(r_ap1[k]));
        end
    end

    always_comb begin
        n_s3 = r_sq2[0] + r_sq2[1] + r_sq2[2];
        for (int k = 0; k < 3; k++) begin
            n_nd3[k] = 52'($signed(r_n2[k]) * $signed(r_d2));
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_off4[k] = OFF_W'(clamp_sym(66'($signed(r_q3[k]))
                                         - sround(66'($signed(r_nd3[k])), 14), OFF_LIMIT));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n1  <= n_n1;
            r_ap1 <= n_ap1;
            r_bp1 <= n_bp1;
            r_pn1 <= n_pn1;
            r_q1  <= i_query;
            r_n2  <= r_n1;
            r_ap2 <= r_ap1;
            r_bp2 <= r_bp1;
            r_q2  <= r_q1;
            r_sq2 <= n_sq2;
            r_d2  <= n_d2;
            r_s3  <= n_s3;
            r_nd3 <= n_nd3;
            r_ap3 <= r_ap2;
            r_bp3 <= r_bp2;
            r_q3  <= r_q2;
            r_s4  <= r_s3;
            r_ap4 <= r_ap3;
            r_bp4 <= r_bp3;
            r_off4 <= n_off4;
        end
    end

    assign o_valid     = r_v4;
    assign o_w         = r_ap4;
    assign o_s         = r_s4;
    assign o_side.off  = r_off4;
    assign o_side.bp   = r_bp4;

endmodule
`default_nettype wire

// ===== design/plc_unit.sv =====
// Unit vector pipeline: bit-serial square root stages, then three restoring
// dividers one quotient bit per stage. Uses plc_pkg.
`default_nettype none
module plc_unit import plc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2:0][31:0]      i_w,
    input  logic [63:0]           i_s,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [2:0][31:0]      o_unit,
    output logic [SIDE_W-1:0]     o_side
);

    logic                  r_sv    [SQ_STEPS];
    logic [63:0]           r_ss    [SQ_STEPS];
    logic [63:0]           r_sres  [SQ_STEPS];
    logic [2:0][31:0]      r_sw    [SQ_STEPS];
    logic [SIDE_W-1:0]     r_sside [SQ_STEPS];

    for (genvar gi = 0; gi < SQ_STEPS; gi++) begin : g_sq
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * gi);
        logic              a_v;
        logic [63:0]       a_s, a_res, trial, n_s, n_res;
        logic [2:0][31:0]  a_w;
        logic [SIDE_W-1:0] a_side;
        if (gi == 0) begin : g_first
            assign a_v    = i_valid;
            assign a_s    = i_s;
            assign a_res  = '0;
            assign a_w    = i_w;
            assign a_side = i_side;
        end else begin : g_next
            assign a_v    = r_sv[gi-1];
            assign a_s    = r_ss[gi-1];
            assign a_res  = r_sres[gi-1];
            assign a_w    = r_sw[gi-1];
            assign a_side = r_sside[gi-1];
        end
        assign trial = a_res + BIT;
        always_comb begin
            if (a_s >= trial) begin
                n_s   = a_s - trial;
                n_res = (a_res >> 1) + BIT;
            end else begin
                n_s   = a_s;
                n_res = a_res >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[gi] <= 1'b0;
            end else if (i_en) begin
                r_sv[gi] <= a_v;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ss[gi]    <= n_s;
                r_sres[gi]  <= n_res;
                r_sw[gi]    <= a_w;
                r_sside[gi] <= a_side;
            end
        end
    end

    logic                   r_pv;
    logic [31:0]            r_pr;
    logic [2:0][NUM_W-1:0]  n_pnum, r_pnum;
    logic [2:0]             n_pneg, r_pneg;
    logic [SIDE_W-1:0]      r_pside;
    logic [31:0]            root;
    logic signed [31:0]     wk;
    logic [31:0]            wabs;

    assign root = r_sres[SQ_STEPS-1][31:0];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            wk        = $signed(r_sw[SQ_STEPS-1][k]);
            wabs      = wk[31] ? 32'(-wk) : 32'(wk);
            n_pneg[k] = wk[31];
            n_pnum[k] = {wabs, 30'd0} + NUM_W'(root[31:1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= r_sv[SQ_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pr    <= root;
            r_pnum  <= n_pnum;
            r_pneg  <= n_pneg;
            r_pside <= r_sside[SQ_STEPS-1];
        end
    end

    logic                        r_dv    [DIV_STEPS];
    logic [31:0]                 r_dr    [DIV_STEPS];
    logic [2:0][NUM_W-1:0]       r_dnum  [DIV_STEPS];
    logic [2:0][31:0]            r_drem  [DIV_STEPS];
    logic [2:0][DIV_STEPS-1:0]   r_dq    [DIV_STEPS];
    logic [2:0]                  r_dneg  [DIV_STEPS];
    logic [SIDE_W-1:0]           r_dside [DIV_STEPS];

    for (genvar gj = 0; gj < DIV_STEPS; gj++) begin : g_div
        logic                       a_v;
        logic [31:0]                a_r;
        logic [2:0][NUM_W-1:0]      a_num;
        logic [2:0][31:0]           a_rem, n_rem;
        logic [2:0][DIV_STEPS-1:0]  a_q, n_q;
        logic [2:0]                 a_neg;
        logic [SIDE_W-1:0]          a_side;
        logic [32:0]                trial;
        if (gj == 0) begin : g_first
            assign a_v    = r_pv;
            assign a_r    = r_pr;
            assign a_num  = r_pnum;
            assign a_neg  = r_pneg;
            assign a_side = r_pside;
            assign a_q    = '0;
            for (genvar k = 0; k < 3; k++) begin : g_lane
                assign a_rem[k] = {1'b0, r_pnum[k][NUM_W-1:DIV_STEPS]};
            end
        end else begin : g_next
            assign a_v    = r_dv[gj-1];
            assign a_r    = r_dr[gj-1];
            assign a_num  = r_dnum[gj-1];
            assign a_neg  = r_dneg[gj-1];
            assign a_side = r_dside[gj-1];
            assign a_q    = r_dq[gj-1];
            assign a_rem  = r_drem[gj-1];
        end
        always_comb begin
            for (int k = 0; k < 3; k++) begin
                trial = {a_rem[k], a_num[k][DIV_STEPS-1-gj]};
                if (trial >= {1'b0, a_r}) begin
                    n_rem[k] = 32'(trial - {1'b0, a_r});
                    n_q[k]   = {a_q[k][DIV_STEPS-2:0], 1'b1};
                end else begin
                    n_rem[k] = trial[31:0];
                    n_q[k]   = {a_q[k][DIV_STEPS-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[gj] <= 1'b0;
            end else if (i_en) begin
                r_dv[gj] <= a_v;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dr[gj]    <= a_r;
                r_dnum[gj]  <= a_num;
                r_drem[gj]  <= n_rem;
                r_dq[gj]    <= n_q;
                r_dneg[gj]  <= a_neg;
                r_dside[gj] <= a_side;
            end
        end
    end

    logic                  r_ov;
    logic [2:0][31:0]      n_ounit, r_ounit;
    logic [SIDE_W-1:0]     r_oside;
    logic [30:0]           mag;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag = (r_dq[DIV_STEPS-1][k] > ONE_Q30) ? ONE_Q30 : r_dq[DIV_STEPS-1][k];
            if (r_dr[DIV_STEPS-1] == '0) begin
                n_ounit[k] = '0;
            end else if (r_dneg[DIV_STEPS-1][k]) begin
                n_ounit[k] = -{1'b0, mag};
            end else begin
                n_ounit[k] = {1'b0, mag};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_dv[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ounit <= n_ounit;
            r_oside <= r_dside[DIV_STEPS-1];
        end
    end

    assign o_valid = r_ov;
    assign o_unit  = r_ounit;
    assign o_side  = r_oside;

    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv && r_pr != '0 |-> r_pnum[0][NUM_W-1:DIV_STEPS] < r_pr
                            && r_pnum[1][NUM_W-1:DIV_STEPS] < r_pr
                            && r_pnum[2][NUM_W-1:DIV_STEPS] < r_pr)
        else $error("divider quotient exceeds its width");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[DIV_STEPS-1] && r_dr[DIV_STEPS-1] != '0
            |-> r_drem[DIV_STEPS-1][0] < r_dr[DIV_STEPS-1]
             && r_drem[DIV_STEPS-1][1] < r_dr[DIV_STEPS-1]
             && r_drem[DIV_STEPS-1][2] < r_dr[DIV_STEPS-1])
        else $error("divider remainder not below divisor");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> $signed(r_ounit[0]) <= $signed({1'b0, ONE_Q30})
              && $signed(r_ounit[0]) >= -$signed({1'b0, ONE_Q30})
              && $signed(r_ounit[1]) <= $signed({1'b0, ONE_Q30})
              && $signed(r_ounit[1]) >= -$signed({1'b0, ONE_Q30})
              && $signed(r_ounit[2]) <= $signed({1'b0, ONE_Q30})
              && $signed(r_ounit[2]) >= -$signed({1'b0, ONE_Q30}))
        else $error("unit vector component out of range");

endmodule
`default_nettype wire

// ===== design/plc_ortho.sv =====
// Gram-Schmidt step: removes the u component from the second projected axis
// and forms its sum of squares. Six register stages; uses plc_pkg.
`default_nettype none
module plc_ortho import plc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2:0][31:0]      i_u,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [2:0][31:0]      o_w,
    output logic [63:0]           o_s,
    output logic [SIDE_W-1:0]     o_side
);

    t_side1 side_in;
    t_side2 side_out;

    logic [5:0]       r_v;
    logic [2:0][31:0] r_u1, r_u2, r_u3, r_u4, r_u5, r_u6;
    logic [2:0][31:0] r_bp1, r_bp2, r_bp3;
    t_off3            r_off1, r_off2, r_off3, r_off4, r_off5, r_off6;
    logic [2:0][63:0] n_pr1, r_pr1;
    logic [33:0]      n_t2, r_t2;
    logic [2:0][65:0] n_ut3, r_ut3;
    logic [2:0][31:0] n_vp4, r_vp4, r_vp5, r_vp6;
    logic [2:0][63:0] n_sq5, r_sq5;
    logic [63:0]      n_s6, r_s6;

    assign side_in = i_side;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_pr1[k] = 64'($signed(i_u[k]) * $signed(side_in.bp[k]));
            n_ut3[k] = 66'($signed(r_u2[k]) * $signed(r_t2));
            n_vp4[k] = 32'(clamp_sym(66'($signed(r_bp3[k])) - sround($signed(r_ut3[k]), 30),
                                     VP_LIMIT));
            n_sq5[k] = 64'($signed(r_vp4[k]) * $signed(r_vp4[k]));
        end
        n_t2 = 34'(sround(66'($signed(r_pr1[0])) + 66'($signed(r_pr1[1]))
                          + 66'($signed(r_pr1[2])), 30));
        n_s6 = r_sq5[0] + r_sq5[1] + r_sq5[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u1   <= i_u;
            r_bp1  <= side_in.bp;
            r_off1 <= side_in.off;
            r_pr1  <= n_pr1;
            r_u2   <= r_u1;
            r_bp2  <= r_bp1;
            r_off2 <= r_off1;
            r_t2   <= n_t2;
            r_u3   <= r_u2;
            r_bp3  <= r_bp2;
            r_off3 <= r_off2;
            r_ut3  <= n_ut3;
            r_u4   <= r_u3;
            r_off4 <= r_off3;
            r_vp4  <= n_vp4;
            r_u5   <= r_u4;
            r_off5 <= r_off4;
            r_vp5  <= r_vp4;
            r_sq5  <= n_sq5;
            r_u6   <= r_u5;
            r_off6 <= r_off5;
            r_vp6  <= r_vp5;
            r_s6   <= n_s6;
        end
    end

    assign side_out.off = r_off6;
    assign side_out.u   = r_u6;
    assign o_valid      = r_v[5];
    assign o_w          = r_vp6;
    assign o_s          = r_s6;
    assign o_side       = side_out;

endmodule
`default_nettype wire

// ===== design/plc_proj.sv =====
// Projection of the offset onto both in-plane axes with rounding and
// saturation. Two register stages, the second is the output register; uses plc_pkg.
`default_nettype none
module plc_proj import plc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2:0][31:0]      i_v,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [31:0]           o_coord_u,
    output logic [31:0]           o_coord_v
);

    t_side2 side_in;

    logic             r_v1, r_v2;
    logic [2:0][65:0] n_pu1, r_pu1, n_pv1, r_pv1;
    logic signed [65:0] su, sv;
    logic [31:0]      n_cu, r_cu, n_cv, r_cv;

    assign side_in = i_side;

    function automatic logic [31:0] sat32(input logic signed [65:0] x);
        if (x > OUT_MAX) begin
            return 32'(OUT_MAX);
        end
        if (x < OUT_MIN) begin
            return 32'(OUT_MIN);
        end
        return 32'(x);
    endfunction

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_pu1[k] = 66'($signed(side_in.off[k]) * $signed(side_in.u[k]));
            n_pv1[k] = 66'($signed(side_in.off[k]) * $signed(i_v[k]));
        end
        su = sround($signed(r_pu1[0]), 30) + sround($signed(r_pu1[1]), 30)
             + sround($signed(r_pu1[2]), 30);
        sv = sround($signed(r_pv1[0]), 30) + sround($signed(r_pv1[1]), 30)
             + sround($signed(r_pv1[2]), 30);
        n_cu = sat32(su);
        n_cv = sat32(sv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pu1 <= n_pu1;
            r_pv1 <= n_pv1;
            r_cu  <= n_cu;
            r_cv  <= n_cv;
        end
    end

    assign o_valid   = r_v2;
    assign o_coord_u = r_cu;
    assign o_coord_v = r_cv;

endmodule
`default_nettype wire

// ===== design/plane_local_coordinates.sv =====
// Plane local coordinates: in-plane (u, v) offsets of a query point.
// Instantiates plc_front, plc_unit (twice), plc_ortho and plc_proj; uses plc_pkg.
//
// One item is taken per clock; the pipeline has 4 front
// stages, 65 stages for each unit vector (32 square root steps, one operand
// stage, 31 quotient steps, one sign and clamp stage), 6 Gram-Schmidt stages and
// 2 projection stages. The pipeline advances as a whole; while a result waits
// at the output with tready low, every stage holds and no input is taken.
`default_nettype none
module plane_local_coordinates import plc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // normal_x, normal_y, normal_z (16 each), plane_point_x/y/z, query_x/y/z (32 each)
    input  logic [239:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // coord_u [31:0], coord_v [63:32]
    output logic [63:0]  o_m_tdata
);

    logic             en;
    logic [2:0][15:0] normal;
    logic [2:0][31:0] point, query;

    logic             f_valid, u_valid, o_valid_w, v_valid;
    logic [2:0][31:0] f_w, u_vec, o_w, v_vec;
    logic [63:0]      f_s, o_s;
    t_side1           f_side;
    logic [SIDE_W-1:0] u_side, o_side, v_side;
    logic [31:0]      coord_u, coord_v;

    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    assign normal = i_s_tdata[47:0];
    assign point  = i_s_tdata[143:48];
    assign query  = i_s_tdata[239:144];

    plc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_s_tvalid && en),
        .i_normal (normal),
        .i_point  (point),
        .i_query  (query),
        .o_valid  (f_valid),
        .o_w      (f_w),
        .o_s      (f_s),
        .o_side   (f_side)
    );

    plc_unit u_unit_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_w     (f_w),
        .i_s     (f_s),
        .i_side  (f_side),
        .o_valid (u_valid),
        .o_unit  (u_vec),
        .o_side  (u_side)
    );

    plc_ortho u_ortho (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (u_valid),
        .i_u     (u_vec),
        .i_side  (u_side),
        .o_valid (o_valid_w),
        .o_w     (o_w),
        .o_s     (o_s),
        .o_side  (o_side)
    );

    plc_unit u_unit_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (o_valid_w),
        .i_w     (o_w),
        .i_s     (o_s),
        .i_side  (o_side),
        .o_valid (v_valid),
        .o_unit  (v_vec),
        .o_side  (v_side)
    );

    plc_proj u_proj (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (v_valid),
        .i_v       (v_vec),
        .i_side    (v_side),
        .o_valid   (o_m_tvalid),
        .o_coord_u (coord_u),
        .o_coord_v (coord_v)
    );

    assign o_m_tdata = {coord_v, coord_u};

endmodule
`default_nettype wire
